// ===== rtl/core/stm_pkg.sv =====
package stm_pkg;

  localparam int unsigned DEFAULT_MAX_DEPTH = 255;
  localparam int unsigned DEPTH_W           = 8;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_BQUOTE  = 8'h60;

  localparam logic [3:0] K_NONE   = 4'd0;
  localparam logic [3:0] K_OPEN   = 4'd1;
  localparam logic [3:0] K_CLOSE  = 4'd2;
  localparam logic [3:0] K_VEC    = 4'd3;
  localparam logic [3:0] K_QUOTE  = 4'd4;
  localparam logic [3:0] K_QQ     = 4'd5;
  localparam logic [3:0] K_UNQ    = 4'd6;
  localparam logic [3:0] K_SPLICE = 4'd7;
  localparam logic [3:0] K_STR    = 4'd8;
  localparam logic [3:0] K_ATOM   = 4'd9;
  localparam logic [3:0] K_END    = 4'd10;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_OPEN_STR = 2'd1;
  localparam logic [1:0] E_UNDERRUN = 2'd2;
  localparam logic [1:0] E_OVERFLOW = 2'd3;

  typedef struct packed {
    logic space;
    logic delim;
    logic newline;
    logic semi;
    logic dquote;
    logic hash;
    logic squote;
    logic bquote;
    logic comma;
    logic open;
    logic close;
    logic at;
    logic bslash;
  } char_class_t;

endpackage

// ===== rtl/core/stm_char_class.sv =====
module stm_char_class (
  input  logic [7:0]          ch,
  output stm_pkg::char_class_t cls
);
  import stm_pkg::*;

  logic space;

  assign space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL) ||
                 (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);

  always_comb begin
    cls.space   = space;
    cls.newline = (ch == CH_NL);
    cls.semi    = (ch == CH_SEMI);
    cls.dquote  = (ch == CH_DQUOTE);
    cls.hash    = (ch == CH_HASH);
    cls.squote  = (ch == CH_SQUOTE);
    cls.bquote  = (ch == CH_BQUOTE);
    cls.comma   = (ch == CH_COMMA);
    cls.open    = (ch == CH_OPEN);
    cls.close   = (ch == CH_CLOSE);
    cls.at      = (ch == CH_AT);
    cls.bslash  = (ch == CH_BSLASH);
    cls.delim   = space || (ch == CH_OPEN) || (ch == CH_CLOSE) || (ch == CH_SEMI) ||
                  (ch == CH_HASH) || (ch == CH_DQUOTE) || (ch == CH_SQUOTE) ||
                  (ch == CH_BQUOTE) || (ch == CH_COMMA);
  end

endmodule

// ===== rtl/core/sexpr_token_marker.sv =====
// S-expression token marker.
// Slave channel: one source byte per request in s_tdata; s_tlast high marks
// the end of the text instead of a byte (s_tdata is then ignored).
// Master channel: one result per request: the byte, token start / in-token
// flags, bracket depth after the byte and an error code in m_tdata, the
// token kind in m_tuser. An end-of-text request yields kind "end", byte zero,
// and leaves the depth as is, so an unclosed expression shows as nonzero.
// A request is loaded into the input register when it is accepted and then into
// the result register, which raises m_tvalid; a stalled result keeps it waiting in
// the input register. Throughput: one request per cycle while the receiver keeps
// up; the lexer mode and depth update together with the result register.
// Reset clears both valid registers, the mode (between tokens) and the depth.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, then s_tready drops until the result drains.
// MAX_DEPTH caps the depth at the lesser of MAX_DEPTH and 255.
module sexpr_token_marker #(
  parameter int unsigned MAX_DEPTH = stm_pkg::DEFAULT_MAX_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] char_in
  input  logic        s_tlast,  // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [7:0] char_out, [8] token_start, [9] in_token,
                                // [17:10] depth, [19:18] error_code, [23:20] zero
  output logic [3:0]  m_tuser   // [3:0] token_kind
);
  import stm_pkg::*;

  localparam logic [DEPTH_W-1:0] DEPTH_CAP =
    (MAX_DEPTH < 255) ? DEPTH_W'(MAX_DEPTH) : DEPTH_W'(255);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_STR, M_STR_ESC, M_ATOM, M_ATOM_ESC, M_HASH, M_COMMA
  } mode_t;

  mode_t              mode, mode_next;
  logic [DEPTH_W-1:0] depth, depth_next;

  logic               in_valid;
  logic [7:0]         in_char;
  logic               in_last;

  logic               out_valid;
  logic [7:0]         out_char;
  logic               out_start;
  logic               out_inside;
  logic [3:0]         out_kind;
  logic [DEPTH_W-1:0] out_depth;
  logic [1:0]         out_err;

  logic               advance;
  char_class_t        cls;

  logic [7:0]         char_next;
  logic               start_next;
  logic               inside_next;
  logic [3:0]         kind_next;
  logic [1:0]         err_next;
  logic               use_idle;
  logic               go_deeper;

  stm_char_class u_class (
    .ch  (in_char),
    .cls (cls)
  );

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_comb begin
    mode_next   = mode;
    depth_next  = depth;
    char_next   = in_char;
    start_next  = 1'b0;
    inside_next = 1'b0;
    kind_next   = K_NONE;
    err_next    = E_NONE;
    use_idle    = 1'b0;
    go_deeper   = 1'b0;

    if (in_last) begin
      if (mode == M_STR || mode == M_STR_ESC) begin
        err_next = E_OPEN_STR;
      end
      start_next  = 1'b1;
      inside_next = 1'b1;
      kind_next   = K_END;
      mode_next   = M_IDLE;
      char_next   = 8'd0;
    end else begin
      case (mode)
        M_COMMENT: begin
          if (cls.newline) begin
            mode_next = M_IDLE;
          end
        end
        M_STR: begin
          inside_next = 1'b1;
          kind_next   = K_STR;
          if (cls.dquote) begin
            mode_next = M_IDLE;
          end else if (cls.bslash) begin
            mode_next = M_STR_ESC;
          end
        end
        M_STR_ESC: begin
          inside_next = 1'b1;
          kind_next   = K_STR;
          mode_next   = M_STR;
        end
        M_ATOM_ESC: begin
          inside_next = 1'b1;
          kind_next   = K_ATOM;
          mode_next   = M_ATOM;
        end
        M_ATOM, M_HASH: begin
          if (mode == M_HASH && cls.open) begin
            // '#(' turns the lone hash into a vector opener
            inside_next = 1'b1;
            kind_next   = K_VEC;
            go_deeper   = 1'b1;
            mode_next   = M_IDLE;
          end else if (cls.delim) begin
            use_idle = 1'b1;
          end else begin
            inside_next = 1'b1;
            kind_next   = K_ATOM;
            mode_next   = cls.bslash ? M_ATOM_ESC : M_ATOM;
          end
        end
        M_COMMA: begin
          if (cls.at) begin
            inside_next = 1'b1;
            kind_next   = K_SPLICE;
            mode_next   = M_IDLE;
          end else begin
            use_idle = 1'b1;
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase

      if (use_idle) begin
        mode_next = M_IDLE;
        if (!cls.space) begin
          if (cls.semi) begin
            mode_next = M_COMMENT;
          end else begin
            start_next  = 1'b1;
            inside_next = 1'b1;
            if (cls.dquote) begin
              kind_next = K_STR;
              mode_next = M_STR;
            end else if (cls.open) begin
              kind_next = K_OPEN;
              go_deeper = 1'b1;
            end else if (cls.close) begin
              kind_next = K_CLOSE;
              if (depth == '0) begin
                err_next = E_UNDERRUN;
              end else begin
                depth_next = depth - DEPTH_W'(1);
              end
            end else if (cls.squote) begin
              kind_next = K_QUOTE;
            end else if (cls.bquote) begin
              kind_next = K_QQ;
            end else if (cls.comma) begin
              kind_next = K_UNQ;
              mode_next = M_COMMA;
            end else if (cls.hash) begin
              kind_next = K_ATOM;
              mode_next = M_HASH;
            end else begin
              kind_next = K_ATOM;
              mode_next = M_ATOM;
            end
          end
        end
      end

      if (go_deeper) begin
        // saturate at the cap and flag it
        if (depth >= DEPTH_CAP) begin
          depth_next = DEPTH_CAP;
          err_next   = E_OVERFLOW;
        end else begin
          depth_next = depth + DEPTH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      mode      <= M_IDLE;
      depth     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
        mode      <= mode_next;
        depth     <= depth_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
    if (advance) begin
      out_char   <= char_next;
      out_start  <= start_next;
      out_inside <= inside_next;
      out_kind   <= kind_next;
      out_depth  <= depth_next;
      out_err    <= err_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_err, out_depth, out_inside, out_start, out_char};
  assign m_tuser  = out_kind;

  a_depth_capped: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_CAP)
    else $error("bracket depth above cap");

  a_overflow_at_cap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err == E_OVERFLOW) |-> (out_depth == DEPTH_CAP))
    else $error("overflow reported below the cap");

  a_end_resets_mode: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (mode == M_IDLE))
    else $error("mode not idle after end of text");

  a_start_in_token: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_start) |-> (out_inside && out_kind != K_NONE))
    else $error("token start without a token");

  a_depth_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_depth == depth))
    else $error("reported depth differs from held depth");

endmodule

// ===== tb/sexpr_token_marker_tb.sv =====
module sexpr_token_marker_tb;
  import stm_pkg::*;

  localparam int unsigned MAX_DEPTH = DEFAULT_MAX_DEPTH;
  localparam int unsigned DEPTH_CAP = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
  localparam int unsigned ITEM_TARGET = 1150;

  typedef struct packed {
    logic [7:0] char_out;
    logic       token_start;
    logic       in_token;
    logic [3:0] kind;
    logic [7:0] depth;
    logic [1:0] err;
  } token_mark_t;

  class lexer_checker;
    typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_COMMENT,
      SCAN_STR,
      SCAN_STR_ESC,
      SCAN_ATOM,
      SCAN_ATOM_ESC,
      SCAN_HASH,
      SCAN_COMMA
    } scan_mode_t;

    scan_mode_t  scan_mode;
    int unsigned bracket_level;
    int unsigned level_cap;
    int unsigned failures;
    token_mark_t expected_marks[$];

    function new(int unsigned cap);
      level_cap     = cap;
      scan_mode     = SCAN_IDLE;
      bracket_level = 0;
      failures      = 0;
    endfunction

    function bit is_space(logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
    endfunction

    function bit is_delim(logic [7:0] c);
      return is_space(c) || (c inside {CH_OPEN, CH_CLOSE, CH_SEMI, CH_HASH, CH_DQUOTE,
                                       CH_SQUOTE, CH_BQUOTE, CH_COMMA});
    endfunction

    function void mark(inout token_mark_t m, input logic start, input logic [3:0] kind);
      m.token_start = start;
      m.in_token    = 1'b1;
      m.kind        = kind;
    endfunction

    // saturate at the cap and flag the overflow
    function void deepen(inout token_mark_t m);
      if (bracket_level >= level_cap) begin
        bracket_level = level_cap;
        m.err         = E_OVERFLOW;
      end else begin
        bracket_level++;
      end
    endfunction

    function void between_tokens(input logic [7:0] c, inout token_mark_t m);
      scan_mode = SCAN_IDLE;
      if (is_space(c)) return;
      case (c)
        CH_SEMI: scan_mode = SCAN_COMMENT;
        CH_DQUOTE: begin
          mark(m, 1'b1, K_STR);
          scan_mode = SCAN_STR;
        end
        CH_OPEN: begin
          mark(m, 1'b1, K_OPEN);
          deepen(m);
        end
        CH_CLOSE: begin
          mark(m, 1'b1, K_CLOSE);
          if (bracket_level == 0) m.err = E_UNDERRUN;
          else bracket_level--;
        end
        CH_SQUOTE: mark(m, 1'b1, K_QUOTE);
        CH_BQUOTE: mark(m, 1'b1, K_QQ);
        CH_COMMA: begin
          mark(m, 1'b1, K_UNQ);
          scan_mode = SCAN_COMMA;
        end
        CH_HASH: begin
          mark(m, 1'b1, K_ATOM);
          scan_mode = SCAN_HASH;
        end
        default: begin
          mark(m, 1'b1, K_ATOM);
          scan_mode = SCAN_ATOM;
        end
      endcase
    endfunction

    function void within_atom(input logic [7:0] c, inout token_mark_t m);
      if (is_delim(c)) begin
        between_tokens(c, m);
      end else begin
        mark(m, 1'b0, K_ATOM);
        if (c == CH_BSLASH) scan_mode = SCAN_ATOM_ESC;
        else scan_mode = SCAN_ATOM;
      end
    endfunction

    function void note_request(logic [7:0] c, logic eoi);
      token_mark_t m;
      m          = '0;
      m.char_out = c;
      m.kind     = K_NONE;
      m.err      = E_NONE;
      if (eoi) begin
        if (scan_mode inside {SCAN_STR, SCAN_STR_ESC}) m.err = E_OPEN_STR;
        mark(m, 1'b1, K_END);
        scan_mode  = SCAN_IDLE;
        m.char_out = 8'd0;
      end else begin
        case (scan_mode)
          SCAN_COMMENT: if (c == CH_NL) scan_mode = SCAN_IDLE;
          SCAN_STR: begin
            mark(m, 1'b0, K_STR);
            if (c == CH_DQUOTE) scan_mode = SCAN_IDLE;
            else if (c == CH_BSLASH) scan_mode = SCAN_STR_ESC;
          end
          SCAN_STR_ESC: begin
            mark(m, 1'b0, K_STR);
            scan_mode = SCAN_STR;
          end
          SCAN_ATOM: within_atom(c, m);
          SCAN_ATOM_ESC: begin
            mark(m, 1'b0, K_ATOM);
            scan_mode = SCAN_ATOM;
          end
          SCAN_HASH: begin
            if (c == CH_OPEN) begin
              mark(m, 1'b0, K_VEC);
              deepen(m);
              scan_mode = SCAN_IDLE;
            end else begin
              within_atom(c, m);
            end
          end
          SCAN_COMMA: begin
            if (c == CH_AT) begin
              mark(m, 1'b0, K_SPLICE);
              scan_mode = SCAN_IDLE;
            end else begin
              between_tokens(c, m);
            end
          end
          default: between_tokens(c, m);
        endcase
      end
      m.depth = bracket_level[7:0];
      expected_marks.push_back(m);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [23:0] tdata, logic [3:0] tuser);
      token_mark_t want;
      if (expected_marks.size() == 0) begin
        $error("unexpected result: tdata %h, tuser %0d", tdata, tuser);
        failures++;
        return;
      end
      want = expected_marks.pop_front();
      compare("char_out", want.char_out, tdata[7:0]);
      compare("token_start", want.token_start, tdata[8]);
      compare("in_token", want.in_token, tdata[9]);
      compare("depth", want.depth, tdata[17:10]);
      compare("error_code", want.err, tdata[19:18]);
      compare("token_kind", want.kind, tuser);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [23:0] m_tdata;
  logic [3:0]  m_tuser;

  bit           gaps_on = 1'b1;
  int unsigned  accepted = 0;
  lexer_checker board = new(DEPTH_CAP);

  sexpr_token_marker #(
    .MAX_DEPTH(MAX_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #1 clk = ~clk;

  // receiver: check on every accepted result, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    m_tready <= !(gaps_on && $urandom_range(99) < 16);
  end

  task automatic send_request(input logic [7:0] c, input logic eoi);
    if (gaps_on && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(3) != 0);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(c, eoi);
    accepted++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_request(c, 1'b0);
  endtask

  function automatic logic [7:0] atom_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255)); while (board.is_delim(c) || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // one lexical fragment: mostly well-formed tokens, some noise and broken input
  task automatic send_fragment();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_byte(space_byte());
    end else if (pick < 34) begin
      if ($urandom_range(3) == 0) send_byte(CH_HASH);
      else send_byte(atom_byte());
      n = $urandom_range(5);
      repeat (n) begin
        if ($urandom_range(5) == 0) begin
          send_byte(CH_BSLASH);
          send_byte(8'($urandom_range(255)));
        end else begin
          send_byte(atom_byte());
        end
      end
    end else if (pick < 46) begin
      send_byte(CH_DQUOTE);
      n = $urandom_range(8);
      repeat (n) begin
        if ($urandom_range(5) == 0) begin
          send_byte(CH_BSLASH);
          if ($urandom_range(1) == 0) send_byte(CH_DQUOTE);
          else send_byte(8'($urandom_range(255)));
        end else begin
          do c = 8'($urandom_range(255)); while (c == CH_DQUOTE || c == CH_BSLASH);
          send_byte(c);
        end
      end
      send_byte(CH_DQUOTE);
    end else if (pick < 52) begin
      send_byte(CH_SEMI);
      n = $urandom_range(6);
      repeat (n) begin
        do c = 8'($urandom_range(255)); while (c == CH_NL);
        send_byte(c);
      end
      send_byte(CH_NL);
    end else if (pick < 64) begin
      if (board.bracket_level < 10) begin
        if ($urandom_range(3) == 0) send_byte(CH_HASH);
        send_byte(CH_OPEN);
      end else begin
        send_byte(CH_CLOSE);
      end
    end else if (pick < 76) begin
      send_byte(CH_CLOSE);
    end else if (pick < 86) begin
      case ($urandom_range(3))
        0: send_byte(CH_SQUOTE);
        1: send_byte(CH_BQUOTE);
        2: send_byte(CH_COMMA);
        default: begin
          send_byte(CH_COMMA);
          send_byte(CH_AT);
        end
      endcase
    end else if (pick < 96) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 98) begin
      send_request(8'($urandom_range(255)), 1'b1);
    end else begin
      // end of text inside an open string
      send_byte(CH_DQUOTE);
      if ($urandom_range(1) == 0) send_byte(CH_BSLASH);
      send_request(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_byte(CH_CLOSE);
    send_byte(CH_SEMI);
    send_byte("a");
    send_request(8'hFF, 1'b1);
    send_byte(CH_HASH);
    send_byte(CH_OPEN);
    send_byte(CH_COMMA);
    send_byte(CH_AT);
    send_byte(CH_SQUOTE);
    send_byte(CH_BQUOTE);
    // a leading backslash does not escape the next byte
    send_byte(CH_BSLASH);
    send_byte(CH_OPEN);
    send_byte("a");
    send_byte(CH_BSLASH);
    send_byte(CH_CLOSE);
    send_byte(CH_SPACE);
    send_byte(CH_DQUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_DQUOTE);
    send_byte("x");
    send_request(8'h00, 1'b1);
    send_byte(CH_CLOSE);
    send_byte(CH_CLOSE);
    send_byte(8'hFF);
    send_byte(CH_VT);

    // nest past the cap, then unwind past zero
    repeat (DEPTH_CAP + 2) send_byte(CH_OPEN);
    repeat (DEPTH_CAP + 2) send_byte(CH_CLOSE);

    while (accepted < ITEM_TARGET) begin
      gaps_on = !(accepted >= 700 && accepted < 950);
      send_fragment();
    end
    gaps_on = 1'b1;
    send_request(8'($urandom_range(255)), 1'b1);
    s_tvalid <= 1'b0;

    waited = 0;
    while (board.expected_marks.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (board.expected_marks.size() != 0) begin
      $error("%0d expected results never arrived", board.expected_marks.size());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sexpr_token_marker.f =====
rtl/core/stm_pkg.sv
rtl/core/stm_char_class.sv
rtl/core/sexpr_token_marker.sv
tb/sexpr_token_marker_tb.sv
